/* src/rrcc_pkg.sv */
// Package for the rain responsive cover controller.
// Register map, fixed scaling constants and stream payload types.
// No dependencies.
package rrcc_pkg;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_RAIN_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_CLOSE_ANGLE    = 3'd1;
    localparam logic [2:0] REG_STEP_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_REOPEN_DELAY   = 3'd3;
    localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd4;

    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_FORCE_ON  = 2'd1;
    localparam logic [1:0] CMD_FORCE_OFF = 2'd2;

    localparam logic [10:0] RST_RAIN_THRESHOLD = 11'd500;
    localparam logic [7:0]  RST_CLOSE_ANGLE    = 8'd90;
    localparam logic [9:0]  RST_STEP_INTERVAL  = 10'd15;
    localparam logic [19:0] RST_REOPEN_DELAY   = 20'd5000;
    localparam logic [9:0]  RST_SAMPLE_PERIOD  = 10'd50;

    // Wet scale: x = 900 - a; intensity = x/7, buzzer = x*19/70 + 10
    localparam logic [9:0]  WET_DRY_LEVEL  = 10'd900;
    localparam logic [13:0] INT_RECIP      = 14'd9363;    // 2^16 / 7, rounded up
    localparam logic [18:0] BUZ_RECIP      = 19'd284614;  // 19 * 2^20 / 70, rounded up
    localparam logic [7:0]  INTENSITY_MAX  = 8'd100;
    localparam logic [8:0]  BUZ_SPAN_MAX   = 9'd190;
    localparam logic [7:0]  BUZ_MIN        = 8'd10;
    localparam logic [7:0]  BUZ_MAX        = 8'd200;

    typedef struct packed {
        logic [1:0] pad;
        logic [9:0] rain_analog;
        logic       rain_digital;
        logic       switch_level;
        logic [1:0] cmd;
    } in_item_t;

    typedef struct packed {
        logic [4:0] pad;
        logic       force_open_flag;
        logic       switch_flag;
        logic       rain_flag;
        logic [6:0] rain_intensity;
        logic       report_valid;
        logic [7:0] buzzer_duty;
        logic [7:0] servo_command;
    } out_item_t;

endpackage

/* src/rain_responsive_cover_controller.sv */
// Rain responsive cover controller, top level.
// One millisecond tick per input transfer; servo stepping, sensor evaluation, buzzer duty.
// Depends on rrcc_pkg.
//
// channel   dir  handshake          content
// s_        in   s_tvalid/s_tready  tick: cmd, switch, rain digital and analog
// m_        out  m_tvalid/m_tready  servo angle, buzzer duty, evaluation flags
// apb       in   psel/penable       five configuration registers at 4*i
//
// Each tick's state updates at the input transfer, and the result
// lands in the output register the same edge. One tick per cycle sustained while m_tready is high.
// s_tready drops only while the output register is full and m_tready is low.
// aresetn is synchronous, active low; no clearing pass.
module rain_responsive_cover_controller (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,  // cmd[1:0] switch_level rain_digital rain_analog[9:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // servo_command[7:0] buzzer_duty[7:0] report_valid rain_intensity[6:0]
    // rain_flag switch_flag force_open_flag
    output logic [31:0]                m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rrcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rrcc_pkg::*;

    logic [10:0] rain_threshold_reg;
    logic [7:0]  close_angle_reg;
    logic [9:0]  step_interval_reg;
    logic [19:0] reopen_delay_reg;
    logic [9:0]  sample_period_reg;

    logic [31:0] time_now_reg;
    logic [31:0] last_sample_reg;
    logic [31:0] last_step_reg;
    logic [31:0] last_rain_reg;
    logic [7:0]  cur_angle_reg;
    logic [7:0]  tgt_angle_reg;
    logic [7:0]  buzzer_reg;
    logic        force_reg;
    logic [6:0]  intensity_reg;
    logic        rain_reg;
    logic        switch_reg;

    logic        m_tvalid_reg;
    out_item_t   m_data_reg;

    in_item_t    in_item;
    logic        s_xfer;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic        force_next;
    logic [31:0] last_rain_cmd;
    logic [31:0] last_rain_next;
    logic [31:0] last_step_next;
    logic [31:0] last_sample_next;
    logic [7:0]  cur_angle_next;
    logic [7:0]  tgt_angle_next;
    logic [7:0]  buzzer_next;
    logic [6:0]  intensity_next;
    logic        rain_next;
    logic        switch_next;
    logic        step_due;
    logic        eval_due;
    logic        rain_now;
    logic        allow;
    logic [9:0]  wet_x;
    logic [23:0] int_prod;
    logic [28:0] buz_prod;
    logic [7:0]  int_q;
    logic [8:0]  buz_q;
    logic [6:0]  int_val;
    logic [7:0]  buz_val;
    out_item_t   out_next;

    assign in_item  = s_tdata;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // APB
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_RAIN_THRESHOLD: prdata = {21'd0, rain_threshold_reg};
            REG_CLOSE_ANGLE:    prdata = {24'd0, close_angle_reg};
            REG_STEP_INTERVAL:  prdata = {22'd0, step_interval_reg};
            REG_REOPEN_DELAY:   prdata = {12'd0, reopen_delay_reg};
            REG_SAMPLE_PERIOD:  prdata = {22'd0, sample_period_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rain_threshold_reg <= RST_RAIN_THRESHOLD;
            close_angle_reg    <= RST_CLOSE_ANGLE;
            step_interval_reg  <= RST_STEP_INTERVAL;
            reopen_delay_reg   <= RST_REOPEN_DELAY;
            sample_period_reg  <= RST_SAMPLE_PERIOD;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RAIN_THRESHOLD: rain_threshold_reg <= pwdata[10:0];
                REG_CLOSE_ANGLE:    close_angle_reg    <= pwdata[7:0];
                REG_STEP_INTERVAL:  step_interval_reg  <= pwdata[9:0];
                REG_REOPEN_DELAY:   reopen_delay_reg   <= pwdata[19:0];
                REG_SAMPLE_PERIOD:  sample_period_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Wet scaling: constant reciprocals, exact over 0..900
    assign wet_x    = (in_item.rain_analog < WET_DRY_LEVEL) ?
                      (WET_DRY_LEVEL - in_item.rain_analog) : 10'd0;
    assign int_prod = wet_x * INT_RECIP;
    assign buz_prod = wet_x * BUZ_RECIP;
    assign int_q    = int_prod[23:16];
    assign buz_q    = buz_prod[28:20];
    assign int_val  = (int_q > INTENSITY_MAX) ? INTENSITY_MAX[6:0] : int_q[6:0];
    assign buz_val  = (buz_q > BUZ_SPAN_MAX) ? BUZ_MAX : (buz_q[7:0] + BUZ_MIN);

    always_comb begin
        force_next     = force_reg;
        last_rain_cmd  = last_rain_reg;
        case (in_item.cmd)
            CMD_FORCE_ON: begin
                force_next    = 1'b1;
                last_rain_cmd = 32'd0;
            end
            CMD_FORCE_OFF: force_next = 1'b0;
            default: ;
        endcase

        step_due       = (cur_angle_reg != tgt_angle_reg) &&
                         ((time_now_reg - last_step_reg) >= {22'd0, step_interval_reg});
        last_step_next = last_step_reg;
        cur_angle_next = cur_angle_reg;
        if (step_due) begin
            last_step_next = time_now_reg;
            cur_angle_next = (tgt_angle_reg > cur_angle_reg) ? cur_angle_reg + 8'd1
                                                             : cur_angle_reg - 8'd1;
        end

        eval_due         = (time_now_reg - last_sample_reg) >= {22'd0, sample_period_reg};
        rain_now         = !in_item.rain_digital &&
                           ({1'b0, in_item.rain_analog} < rain_threshold_reg);
        last_rain_next   = (eval_due && rain_now) ? time_now_reg : last_rain_cmd;
        allow            = (time_now_reg - last_rain_next) > {12'd0, reopen_delay_reg};
        last_sample_next = last_sample_reg;
        rain_next        = rain_reg;
        switch_next      = switch_reg;
        intensity_next   = intensity_reg;
        tgt_angle_next   = tgt_angle_reg;
        buzzer_next      = buzzer_reg;
        if (eval_due) begin
            last_sample_next = time_now_reg;
            rain_next        = rain_now;
            switch_next      = in_item.switch_level;
            intensity_next   = int_val;
            if (force_next) begin
                tgt_angle_next = 8'd0;
                buzzer_next    = 8'd0;
            end else begin
                tgt_angle_next = (in_item.switch_level || rain_now || !allow) ?
                                 close_angle_reg : 8'd0;
                buzzer_next    = (tgt_angle_next == close_angle_reg &&
                                  cur_angle_next != close_angle_reg) ? buz_val : 8'd0;
            end
        end

        out_next                 = '0;
        out_next.servo_command   = cur_angle_next;
        out_next.buzzer_duty     = buzzer_next;
        out_next.report_valid    = eval_due;
        out_next.rain_intensity  = intensity_next;
        out_next.rain_flag       = rain_next;
        out_next.switch_flag     = switch_next;
        out_next.force_open_flag = force_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_now_reg    <= 32'd0;
            last_sample_reg <= 32'd0;
            last_step_reg   <= 32'd0;
            last_rain_reg   <= 32'd0;
            cur_angle_reg   <= 8'd0;
            tgt_angle_reg   <= 8'd0;
            buzzer_reg      <= 8'd0;
            force_reg       <= 1'b0;
            intensity_reg   <= 7'd0;
            rain_reg        <= 1'b0;
            switch_reg      <= 1'b0;
        end else if (s_xfer) begin
            time_now_reg    <= time_now_reg + 32'd1;
            last_sample_reg <= last_sample_next;
            last_step_reg   <= last_step_next;
            last_rain_reg   <= last_rain_next;
            cur_angle_reg   <= cur_angle_next;
            tgt_angle_reg   <= tgt_angle_next;
            buzzer_reg      <= buzzer_next;
            force_reg       <= force_next;
            intensity_reg   <= intensity_next;
            rain_reg        <= rain_next;
            switch_reg      <= switch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= out_next;
        end
    end

    // Checks
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid_reg)
        else $error("accepted tick left no result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_data_reg))
        else $error("result changed while stalled");

    a_servo_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(s_xfer) |-> $stable(cur_angle_reg))
        else $error("servo moved without a tick");

    a_buzzer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        buzzer_reg == 8'd0 || (buzzer_reg >= BUZ_MIN && buzzer_reg <= BUZ_MAX))
        else $error("buzzer duty out of range");

    a_force_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && eval_due && force_next) |=> buzzer_reg == 8'd0)
        else $error("buzzer active under force open");

endmodule

/* tb/sv/tb_rain_responsive_cover_controller.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rain_responsive_cover_controller: directed ticks, then random
// weather runs under several register settings, each result checked against its row or a local model.
// Depends on rrcc_pkg and the DUT sources.
module tb_rain_responsive_cover_controller;
    import rrcc_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int ZERO_INTERVAL_ROW = 4;
    localparam int N_DIRECTED = 23;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    rain_responsive_cover_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // register mirror
    logic [10:0] thr_cfg    = RST_RAIN_THRESHOLD;
    logic [7:0]  angle_cfg  = RST_CLOSE_ANGLE;
    logic [9:0]  step_cfg   = RST_STEP_INTERVAL;
    logic [19:0] reopen_cfg = RST_REOPEN_DELAY;
    logic [9:0]  sample_cfg = RST_SAMPLE_PERIOD;

    // controller state
    logic [31:0] clk_ms = '0;
    logic [31:0] last_sample_ms = '0;
    logic [31:0] last_step_ms = '0;
    logic [31:0] last_rain_ms = '0;
    logic [7:0]  angle_now = '0;
    logic [7:0]  angle_goal = '0;
    logic [7:0]  buzzer = '0;
    logic        latch = 1'b0;
    logic [6:0]  intensity = '0;
    logic        rain_seen = 1'b0;
    logic        switch_seen = 1'b0;

    out_item_t pending_reports[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        hold_cnt = 0;
    bit        calm = 1'b0;

    typedef struct {
        logic [1:0] cmd;
        bit         sw;
        bit         dig;
        logic [9:0] ana;
        bit         typed;
        logic [7:0] servo;
        logic [7:0] buzz;
        bit         valid;
        logic [6:0] inten;
        bit         rain;
        bit         swf;
        bit         force_flag;
    } tick_row_t;

    // cmd, switch, digital, analog, typed | servo, buzzer, valid, intensity, rain, switch, force
    tick_row_t dir_rows [N_DIRECTED] = '{
        '{CMD_NONE,      0, 1, 1023, 1, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_FORCE_ON,  0, 1, 1023, 1, 0,   0, 0,   0, 0, 0, 1},
        '{CMD_RESERVED,  1, 0,    0, 1, 0,   0, 0,   0, 0, 0, 1},
        '{CMD_FORCE_OFF, 0, 1, 1023, 1, 0,   0, 0,   0, 0, 0, 0},
        // step interval and sample period now zero
        '{CMD_NONE,      0, 0,    0, 1, 0, 200, 1, 100, 1, 0, 0},
        '{CMD_NONE,      0, 1, 1023, 1, 1,  10, 1,   0, 0, 0, 0},
        '{CMD_FORCE_ON,  1, 0,  200, 1, 2,   0, 1, 100, 1, 1, 1},
        '{CMD_FORCE_OFF, 0, 1,  900, 1, 1,  10, 1,   0, 0, 0, 0},
        '{CMD_NONE,      1, 1, 1023, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  499, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  500, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 1,  499, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  899, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  901, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  201, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  199, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      1, 0,  682, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 1,  341, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_RESERVED,  1, 0,  300, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_FORCE_ON,  0, 0,  100, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 0,  100, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_FORCE_OFF, 0, 1, 1000, 0, 0,   0, 0,   0, 0, 0, 0},
        '{CMD_NONE,      0, 1, 1000, 0, 0,   0, 0,   0, 0, 0, 0}
    };

    typedef struct {
        int thr;
        int angle;
        int step;
        int reopen;
        int sample;
    } cover_setting_t;

    cover_setting_t settings [N_PHASES] = '{
        '{500,  90,   15,    5000,   50},
        '{1024, 180,  1,     20,     1},
        '{0,    0,    3,     0,      2},
        '{2047, 255,  0,     40,     0},
        '{700,  45,   1000,  600000, 1000},
        '{600,  30,   2,     1048575, 5},
        '{512,  1,    0,     5,      1},
        '{800,  120,  1,     10,     3}
    };

    function automatic int wetness_scale(int a, int lo, int hi);
        int v;
        v = (a - 900) * (hi - lo) / -700 + lo;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic out_item_t predict_cover_tick(in_item_t tk);
        out_item_t r;
        logic [31:0] t;
        bit evaluated;
        bit reopen_ok;
        r = '0;
        t = clk_ms;
        evaluated = 1'b0;
        if (tk.cmd == CMD_FORCE_ON) begin
            latch = 1'b1;
            last_rain_ms = '0;
        end else if (tk.cmd == CMD_FORCE_OFF) begin
            latch = 1'b0;
        end
        if (angle_now != angle_goal && (t - last_step_ms) >= 32'(step_cfg)) begin
            last_step_ms = t;
            angle_now = (angle_goal > angle_now) ? angle_now + 8'd1 : angle_now - 8'd1;
        end
        if ((t - last_sample_ms) >= 32'(sample_cfg)) begin
            evaluated = 1'b1;
            last_sample_ms = t;
            rain_seen = (tk.rain_digital == 1'b0) && (11'(tk.rain_analog) < thr_cfg);
            switch_seen = tk.switch_level;
            intensity = 7'(wetness_scale(int'(tk.rain_analog), 0, 100));
            if (rain_seen) last_rain_ms = t;
            reopen_ok = (t - last_rain_ms) > 32'(reopen_cfg);
            if (latch) begin
                angle_goal = '0;
                buzzer = '0;
            end else begin
                angle_goal = (switch_seen || rain_seen || !reopen_ok) ? angle_cfg : 8'd0;
                if (angle_goal == angle_cfg && angle_now != angle_cfg)
                    buzzer = 8'(wetness_scale(int'(tk.rain_analog), 10, 200));
                else
                    buzzer = '0;
            end
        end
        clk_ms = t + 32'd1;
        r.servo_command   = angle_now;
        r.buzzer_duty     = buzzer;
        r.report_valid    = evaluated;
        r.rain_intensity  = intensity;
        r.rain_flag       = rain_seen;
        r.switch_flag     = switch_seen;
        r.force_open_flag = latch;
        return r;
    endfunction

    task automatic send_tick(in_item_t tk, bit typed, out_item_t want);
        out_item_t pred;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata  <= tk;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pred = predict_cover_tick(tk);
        pending_reports.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RAIN_THRESHOLD: thr_cfg    = val[10:0];
            REG_CLOSE_ANGLE:    angle_cfg  = val[7:0];
            REG_STEP_INTERVAL:  step_cfg   = val[9:0];
            REG_REOPEN_DELAY:   reopen_cfg = val[19:0];
            REG_SAMPLE_PERIOD:  sample_cfg = val[9:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // result sink with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_tready <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_cnt <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t got;
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: %h", m_tdata);
            end else begin
                want = pending_reports.pop_front();
                if (got.servo_command !== want.servo_command ||
                    got.buzzer_duty !== want.buzzer_duty ||
                    got.report_valid !== want.report_valid ||
                    got.rain_intensity !== want.rain_intensity ||
                    got.rain_flag !== want.rain_flag ||
                    got.switch_flag !== want.switch_flag ||
                    got.force_open_flag !== want.force_open_flag) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: servo %0d/%0d buzzer %0d/%0d valid %0d/%0d",
                                 want.servo_command, got.servo_command,
                                 want.buzzer_duty, got.buzzer_duty,
                                 want.report_valid, got.report_valid);
                        $display("  intensity %0d/%0d rain %0d/%0d switch %0d/%0d force %0d/%0d",
                                 want.rain_intensity, got.rain_intensity,
                                 want.rain_flag, got.rain_flag,
                                 want.switch_flag, got.switch_flag,
                                 want.force_open_flag, got.force_open_flag);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("rain_responsive_cover_controller verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        in_item_t  tk;
        out_item_t want;
        bit        wet;
        bit        sw_on;
        int        sel;
        wet = 1'b0;
        sw_on = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (i == ZERO_INTERVAL_ROW) begin
                drain_results();
                cfg_write(REG_SAMPLE_PERIOD, 32'd0);
                cfg_write(REG_STEP_INTERVAL, 32'd0);
            end
            tk = '0;
            tk.cmd = dir_rows[i].cmd;
            tk.switch_level = dir_rows[i].sw;
            tk.rain_digital = dir_rows[i].dig;
            tk.rain_analog = dir_rows[i].ana;
            want = '0;
            want.servo_command = dir_rows[i].servo;
            want.buzzer_duty = dir_rows[i].buzz;
            want.report_valid = dir_rows[i].valid;
            want.rain_intensity = dir_rows[i].inten;
            want.rain_flag = dir_rows[i].rain;
            want.switch_flag = dir_rows[i].swf;
            want.force_open_flag = dir_rows[i].force_flag;
            send_tick(tk, dir_rows[i].typed, want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            cfg_write(REG_RAIN_THRESHOLD, settings[p].thr);
            cfg_write(REG_CLOSE_ANGLE, settings[p].angle);
            cfg_write(REG_STEP_INTERVAL, settings[p].step);
            cfg_write(REG_REOPEN_DELAY, settings[p].reopen);
            cfg_write(REG_SAMPLE_PERIOD, settings[p].sample);
            calm = (p == N_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // weather and switch come in runs so that reopen hold-offs expire
                if ($urandom_range(0, 29) == 0) wet = !wet;
                if ($urandom_range(0, 39) == 0) sw_on = !sw_on;
                sel = $urandom_range(0, 99);
                tk = '0;
                tk.cmd = (sel < 2) ? CMD_FORCE_ON :
                         (sel < 4) ? CMD_FORCE_OFF :
                         (sel < 5) ? CMD_RESERVED : CMD_NONE;
                tk.switch_level = sw_on ^ ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 7) == 0) begin
                    tk.rain_digital = 1'($urandom_range(0, 1));
                    tk.rain_analog = 10'($urandom_range(0, 1023));
                end else if (wet) begin
                    tk.rain_digital = ($urandom_range(0, 9) == 0);
                    tk.rain_analog = 10'($urandom_range(0, 650));
                end else begin
                    tk.rain_digital = ($urandom_range(0, 9) != 0);
                    tk.rain_analog = 10'($urandom_range(350, 1023));
                end
                send_tick(tk, 1'b0, '0);
            end
        end

        drain_results();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("rain_responsive_cover_controller verification clean");
        else
            $display("rain_responsive_cover_controller verification failed");
        $finish;
    end

endmodule
